// File: src/fct_pkg.sv
package fct_pkg;

    // Command codes on the input channel
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Bus address of the status read
    localparam logic [1:0] ADDR_STATUS = 2'd0;

    // Timer registers, port 0
    localparam logic [7:0] REG_TA_HI = 8'h24;
    localparam logic [7:0] REG_TA_LO = 8'h25;
    localparam logic [7:0] REG_TB    = 8'h26;
    localparam logic [7:0] REG_CTRL  = 8'h27;

    // Control bits 7..6 value that selects CSM
    localparam logic [1:0] CSM_SEL = 2'b10;

    localparam int PER_A_W = 10;
    localparam int PER_B_W = 8;
    localparam int CNT_A_W = 11;
    localparam int CNT_B_W = 13;

    // Timer A reload base, 1024
    localparam logic [CNT_A_W-1:0] BASE_A = 11'd1024;
    // Timer B reload base, 256, before the x16 prescale
    localparam logic [PER_B_W:0]   BASE_B = 9'd256;

    typedef struct packed {
        logic [1:0] command;
        logic [1:0] address;
        logic [7:0] write_data;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       csm_key_on;
    } result_t;

endpackage

// File: src/fct_timer_core.sv
module fct_timer_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  fct_pkg::item_t   item,
    output fct_pkg::result_t res
);
    import fct_pkg::*;

    logic [7:0]         register_latch_reg, register_latch_next;
    logic               port_latch_reg, port_latch_next;
    logic [PER_A_W-1:0] period_a_reg, period_a_next;
    logic [PER_B_W-1:0] period_b_reg, period_b_next;
    logic [CNT_A_W-1:0] count_a_reg, count_a_next;
    logic [CNT_B_W-1:0] count_b_reg, count_b_next;
    logic [1:0]         running_reg, running_next;
    logic [1:0]         flag_enable_reg, flag_enable_next;
    logic [1:0]         status_flags_reg, status_flags_next;
    logic               csm_mode_reg, csm_mode_next;

    logic [CNT_A_W-1:0] reload_a;
    logic [CNT_B_W-1:0] reload_b;
    logic [CNT_A_W-1:0] count_a_dec;
    logic [CNT_B_W-1:0] count_b_dec;

    assign reload_a    = BASE_A - {1'b0, period_a_reg};
    assign reload_b    = {BASE_B - {1'b0, period_b_reg}, 4'b0000};
    assign count_a_dec = count_a_reg - {{(CNT_A_W-1){1'b0}}, 1'b1};
    assign count_b_dec = count_b_reg - {{(CNT_B_W-1){1'b0}}, 1'b1};

    always_comb begin
        register_latch_next = register_latch_reg;
        port_latch_next     = port_latch_reg;
        period_a_next       = period_a_reg;
        period_b_next       = period_b_reg;
        count_a_next        = count_a_reg;
        count_b_next        = count_b_reg;
        running_next        = running_reg;
        flag_enable_next    = flag_enable_reg;
        status_flags_next   = status_flags_reg;
        csm_mode_next       = csm_mode_reg;
        res                 = '0;

        if (fire) begin
            case (item.command)
                CMD_WRITE: begin
                    if (!item.address[0]) begin
                        register_latch_next = item.write_data;
                        port_latch_next     = item.address[1];
                    end else if (!port_latch_reg) begin
                        case (register_latch_reg)
                            REG_TA_HI: period_a_next = {item.write_data, period_a_reg[1:0]};
                            REG_TA_LO: period_a_next = {period_a_reg[PER_A_W-1:2],
                                                        item.write_data[1:0]};
                            REG_TB:    period_b_next = item.write_data;
                            REG_CTRL: begin
                                // a change of a start bit reloads that counter
                                if (running_reg[0] != item.write_data[0]) begin
                                    running_next[0] = item.write_data[0];
                                    count_a_next    = reload_a;
                                end
                                if (running_reg[1] != item.write_data[1]) begin
                                    running_next[1] = item.write_data[1];
                                    count_b_next    = reload_b;
                                end
                                flag_enable_next = item.write_data[3:2];
                                if (item.write_data[4]) status_flags_next[0] = 1'b0;
                                if (item.write_data[5]) status_flags_next[1] = 1'b0;
                                csm_mode_next = (item.write_data[7:6] == CSM_SEL);
                            end
                            default: ;
                        endcase
                    end
                end
                CMD_READ: begin
                    if (item.address == ADDR_STATUS) begin
                        res.read_data = {6'b000000, status_flags_reg};
                    end
                end
                CMD_TICK: begin
                    if (running_reg[0]) begin
                        count_a_next = count_a_dec;
                        if (count_a_dec == '0) begin
                            count_a_next = reload_a;
                            if (flag_enable_reg[0]) status_flags_next[0] = 1'b1;
                            res.csm_key_on = csm_mode_reg;
                        end
                    end
                    if (running_reg[1]) begin
                        count_b_next = count_b_dec;
                        if (count_b_dec == '0) begin
                            count_b_next = reload_b;
                            if (flag_enable_reg[1]) status_flags_next[1] = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            register_latch_reg <= '0;
            port_latch_reg     <= 1'b0;
            period_a_reg       <= '0;
            period_b_reg       <= '0;
            count_a_reg        <= '0;
            count_b_reg        <= '0;
            running_reg        <= '0;
            flag_enable_reg    <= '0;
            status_flags_reg   <= '0;
            csm_mode_reg       <= 1'b0;
        end else begin
            register_latch_reg <= register_latch_next;
            port_latch_reg     <= port_latch_next;
            period_a_reg       <= period_a_next;
            period_b_reg       <= period_b_next;
            count_a_reg        <= count_a_next;
            count_b_reg        <= count_b_next;
            running_reg        <= running_next;
            flag_enable_reg    <= flag_enable_next;
            status_flags_reg   <= status_flags_next;
            csm_mode_reg       <= csm_mode_next;
        end
    end

`ifndef SYNTHESIS
    // counters only move on a tick or a control write
    a_cnt_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && item.command == CMD_READ) |=> ($stable(count_a_reg) && $stable(count_b_reg)))
        else $error("timer counter moved on a read");

    // a flag can only rise while it is enabled
    a_flag_en: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(status_flags_reg[0]) |-> $past(flag_enable_reg[0]))
        else $error("timer A flag set while disabled");

    // key-on needs CSM mode and a running timer A
    a_key_csm: assert property (@(posedge aclk) disable iff (!aresetn)
        res.csm_key_on |-> (fire && csm_mode_reg && running_reg[0]
                            && item.command == CMD_TICK))
        else $error("CSM key-on without CSM tick");
`endif

endmodule

// File: src/fm_chip_timer_unit.sv
// Timer section of an FM sound chip: Timer A, Timer B, status flags and CSM.
// Input channel (s_*): one item per bus write, bus read or sample tick.
//   s_command 0 = write, 1 = read, 2 = sample tick; s_address bit0 selects
//   address latch (0) or data (1), bit1 the port.
// Result channel (m_*): exactly one item per input item, in order.
//   m_read_data is the status byte on a read of address 0, else 0;
//   m_csm_key_on pulses when Timer A overflows on a tick in CSM mode.
// Throughput: one item per cycle while m_ready is high; the input
//   register and the result register each hold one item, and the timer
//   state updates as an item moves from the first into the second.
// Reset (aresetn low, synchronous): all timer state, latches and the valid
//   bits of both pipeline registers clear; no result is pending afterwards.
// Stall: while m_ready is low the result is held; one more item is taken
//   into the input register, then s_ready drops until the result drains.
module fm_chip_timer_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_command,
    input  logic [1:0] s_address,
    input  logic [7:0] s_write_data,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data,
    output logic       m_csm_key_on
);
    import fct_pkg::*;

    // input register
    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;

    // result register
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;

    result_t core_res;
    logic    advance;   // item moves from input register into result register

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign in_valid_next  = (s_valid && s_ready) || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    fct_timer_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .item    (in_item_reg),
        .res     (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.command    <= s_command;
            in_item_reg.address    <= s_address;
            in_item_reg.write_data <= s_write_data;
        end
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_read_data  = out_res_reg.read_data;
    assign m_csm_key_on = out_res_reg.csm_key_on;

`ifndef SYNTHESIS
    // with the result register empty the input side never stalls
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("input stalled with result register empty");

    // a held item moves on once the result register is free
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("item lost between input and result registers");

    // a stalled result keeps its value
    a_res_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> $stable(out_res_reg))
        else $error("result changed while stalled");
`endif

endmodule
